// ===== rtl/csf_pkg.sv =====
// csf_pkg: shared types and constants for the counting semaphore block
// holds operation and result codes, fsm states and the ctrl/datapath structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package csf_pkg;

  // fixed field widths
  localparam int COUNT_W = 18;
  localparam int INIT_W  = 16;
  localparam int FUNC_W  = 2;
  localparam int KIND_W  = 3;

  // saturation point of the count
  localparam logic signed [COUNT_W-1:0] COUNT_TOP = 18'sd131071;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WAIT   = 2'd0,
    FUNC_SIGNAL = 2'd1,
    FUNC_CLOSE  = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_t;

  // result codes
  typedef enum logic [KIND_W-1:0] {
    KIND_PROCEED      = 3'd0,
    KIND_BLOCKED      = 3'd1,
    KIND_WOKEN_SIGNAL = 3'd2,
    KIND_WOKEN_CLOSE  = 3'd3,
    KIND_NO_WAITER    = 3'd4,
    KIND_FULL         = 3'd5
  } kind_t;

  // source of the result thread id
  typedef enum logic [1:0] {
    SEL_CALLER = 2'd0,
    SEL_WAITER = 2'd1,
    SEL_ZERO   = 2'd2
  } thr_sel_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EXEC  = 2'd1,
    ST_DRAIN = 2'd2
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     load;
    logic     cnt_dec;
    logic     cnt_inc;
    logic     cnt_reload;
    logic     push;
    logic     pop;
    logic     ring_clear;
    logic     emit;
    kind_t    kind;
    thr_sel_t sel;
    logic     last;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    func_t func;
    logic  count_pos;
    logic  ring_full;
    logic  ring_empty;
    logic  ring_one;
    logic  out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/counting_semaphore_fifo_unit.sv =====
// counting_semaphore_fifo_unit: counting semaphore with a ring of waiting threads
// top level joining csf_ctrl and csf_datapath
// depends on csf_pkg, csf_ctrl, csf_datapath
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------
//   in      | in_valid / in_ready  | func, thread_id
//   out     | out_valid / out_ready| kind, result_thread, last
//   cfg     | cfg_valid / cfg_ready| cfg_data (initial count)
//
// wait and signal are accepted in idle, then one execute state updates
// the count and the ring and loads the output register.
// close with an empty ring also finishes in execute; with waiters the drain
// pops one waiter per cycle through the single ring read port when not stalled.
// a full output register holds execution until the beat is taken.
// synchronous reset clears count, ring pointers, initial count and handshakes.
`timescale 1ns / 1ps
`default_nettype none

module counting_semaphore_fifo_unit #(
  parameter int WAIT_DEPTH     = 16,
  parameter int THREAD_ID_BITS = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [csf_pkg::FUNC_W-1:0]  func,
  input  wire logic [THREAD_ID_BITS-1:0]   thread_id,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [csf_pkg::KIND_W-1:0]       kind,
  output logic [THREAD_ID_BITS-1:0]        result_thread,
  output logic                             last,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [csf_pkg::INIT_W-1:0]  cfg_data
);

  csf_pkg::cmd_t    cmd;
  csf_pkg::status_t status;
  csf_pkg::kind_t   out_kind;

  // config writes are always taken
  assign cfg_ready = 1'b1;
  assign kind      = out_kind;

  csf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  csf_datapath #(
    .WAIT_DEPTH     (WAIT_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .func       (func),
    .thread_id  (thread_id),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_kind   (out_kind),
    .out_thread (result_thread),
    .out_last   (last),
    .cmd        (cmd),
    .status     (status)
  );

`ifndef SYNTHESIS
  // never queue into a full ring
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !status.ring_full)
    else $error("push into full waiter ring");

  // never release from an empty ring
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !status.ring_empty)
    else $error("pop from empty waiter ring");

  // a result is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result overwrites pending output beat");

  // one item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous item in flight");
`endif

endmodule

`default_nettype wire

// ===== rtl/csf_ctrl.sv =====
// csf_ctrl: controller fsm of the counting semaphore block
// decodes the held operation and sequences count, ring and result updates
// depends on csf_pkg
`timescale 1ns / 1ps
`default_nettype none

module csf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire csf_pkg::status_t status,
  output csf_pkg::cmd_t         cmd
);

  csf_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.cnt_dec    = 1'b0;
    cmd.cnt_inc    = 1'b0;
    cmd.cnt_reload = 1'b0;
    cmd.push       = 1'b0;
    cmd.pop        = 1'b0;
    cmd.ring_clear = 1'b0;
    cmd.emit       = 1'b0;
    cmd.kind       = csf_pkg::KIND_PROCEED;
    cmd.sel        = csf_pkg::SEL_CALLER;
    cmd.last       = 1'b1;
    case (state)
      csf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = csf_pkg::ST_EXEC;
        end
      end
      csf_pkg::ST_EXEC: begin
        case (status.func)
          csf_pkg::FUNC_WAIT: begin
            if (status.out_free) begin
              cmd.emit   = 1'b1;
              state_next = csf_pkg::ST_IDLE;
              if (status.count_pos) begin
                cmd.cnt_dec = 1'b1;
                cmd.kind    = csf_pkg::KIND_PROCEED;
              end else if (status.ring_full) begin
                cmd.kind = csf_pkg::KIND_FULL;
              end else begin
                cmd.cnt_dec = 1'b1;
                cmd.push    = 1'b1;
                cmd.kind    = csf_pkg::KIND_BLOCKED;
              end
            end
          end
          csf_pkg::FUNC_SIGNAL: begin
            if (status.out_free) begin
              cmd.emit    = 1'b1;
              cmd.cnt_inc = 1'b1;
              state_next  = csf_pkg::ST_IDLE;
              if (status.ring_empty) begin
                cmd.kind = csf_pkg::KIND_NO_WAITER;
                cmd.sel  = csf_pkg::SEL_ZERO;
              end else begin
                cmd.pop  = 1'b1;
                cmd.kind = csf_pkg::KIND_WOKEN_SIGNAL;
                cmd.sel  = csf_pkg::SEL_WAITER;
              end
            end
          end
          csf_pkg::FUNC_CLOSE: begin
            if (!status.ring_empty) begin
              state_next = csf_pkg::ST_DRAIN;
            end else if (status.out_free) begin
              cmd.emit       = 1'b1;
              cmd.kind       = csf_pkg::KIND_NO_WAITER;
              cmd.sel        = csf_pkg::SEL_ZERO;
              cmd.ring_clear = 1'b1;
              cmd.cnt_reload = 1'b1;
              state_next     = csf_pkg::ST_IDLE;
            end
          end
          default: begin
            // unused operation: no result, count and ring unchanged, back to idle
            state_next = csf_pkg::ST_IDLE;
          end
        endcase
      end
      csf_pkg::ST_DRAIN: begin
        // release one waiter per free output slot, oldest first
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.pop  = 1'b1;
          cmd.kind = csf_pkg::KIND_WOKEN_CLOSE;
          cmd.sel  = csf_pkg::SEL_WAITER;
          cmd.last = status.ring_one;
          if (status.ring_one) begin
            cmd.ring_clear = 1'b1;
            cmd.cnt_reload = 1'b1;
            state_next     = csf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = csf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/csf_datapath.sv =====
// csf_datapath: count, waiter ring, config register and output register
// executes commands from csf_ctrl and reports status back
// depends on csf_pkg
`timescale 1ns / 1ps
`default_nettype none

module csf_datapath #(
  parameter int WAIT_DEPTH     = 16,
  parameter int THREAD_ID_BITS = 6
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [csf_pkg::FUNC_W-1:0]      func,
  input  wire logic [THREAD_ID_BITS-1:0]       thread_id,
  input  wire logic                            cfg_valid,
  input  wire logic [csf_pkg::INIT_W-1:0]      cfg_data,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output csf_pkg::kind_t                       out_kind,
  output logic [THREAD_ID_BITS-1:0]            out_thread,
  output logic                                 out_last,
  input  wire csf_pkg::cmd_t                   cmd,
  output csf_pkg::status_t                     status
);

  localparam int PTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int USED_W = $clog2(WAIT_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WAIT_DEPTH - 1);
  localparam logic [USED_W-1:0] USED_MAX = USED_W'(WAIT_DEPTH);

  csf_pkg::func_t                     func_q;
  logic [THREAD_ID_BITS-1:0]          tid_q;
  logic [csf_pkg::INIT_W-1:0]         init_count;
  logic signed [csf_pkg::COUNT_W-1:0] count, count_next;
  logic [PTR_W-1:0]                   head, head_next;
  logic [PTR_W-1:0]                   tail, tail_next;
  logic [USED_W-1:0]                  used, used_next;
  logic [THREAD_ID_BITS-1:0]          mem [WAIT_DEPTH];
  logic [THREAD_ID_BITS-1:0]          rd_data;
  logic [THREAD_ID_BITS-1:0]          thread_sel;

  // held item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= csf_pkg::func_t'(func);
      tid_q  <= thread_id;
    end
  end

  // initial count register
  always_ff @(posedge clk) begin
    if (rst) begin
      init_count <= '0;
    end else if (cfg_valid) begin
      init_count <= cfg_data;
    end
  end

  // count update: reload, decrement, saturating increment
  always_comb begin
    count_next = count;
    if (cmd.cnt_reload) begin
      count_next = csf_pkg::COUNT_W'({2'b00, init_count});
    end else if (cmd.cnt_dec) begin
      count_next = count - 18'sd1;
    end else if (cmd.cnt_inc && (count != csf_pkg::COUNT_TOP)) begin
      count_next = count + 18'sd1;
    end
  end

  // ring pointers and occupancy
  always_comb begin
    head_next = head;
    tail_next = tail;
    used_next = used;
    if (cmd.ring_clear) begin
      head_next = '0;
      tail_next = '0;
      used_next = '0;
    end else begin
      if (cmd.pop) begin
        head_next = (head == PTR_LAST) ? '0 : head + PTR_W'(1);
        used_next = used - USED_W'(1);
      end
      if (cmd.push) begin
        tail_next = (tail == PTR_LAST) ? '0 : tail + PTR_W'(1);
        used_next = used + USED_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      head  <= '0;
      tail  <= '0;
      used  <= '0;
    end else begin
      count <= count_next;
      head  <= head_next;
      tail  <= tail_next;
      used  <= used_next;
    end
  end

  // waiter ring memory, read port follows the next head
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= tid_q;
    end
    rd_data <= mem[head_next];
  end

  // result thread source
  always_comb begin
    case (cmd.sel)
      csf_pkg::SEL_CALLER: thread_sel = tid_q;
      csf_pkg::SEL_WAITER: thread_sel = rd_data;
      default:             thread_sel = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind   <= cmd.kind;
      out_thread <= thread_sel;
      out_last   <= cmd.last;
    end
  end

  // status to controller
  assign status.func       = func_q;
  assign status.count_pos  = (count > 18'sd0);
  assign status.ring_full  = (used == USED_MAX);
  assign status.ring_empty = (used == '0);
  assign status.ring_one   = (used == USED_W'(1));
  assign status.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== verif/tb_counting_semaphore_fifo_unit.sv =====
// tb_counting_semaphore_fifo_unit: self-checking bench for the counting semaphore
// directed table and randomized phases, checked by a predictor
// depends on csf_pkg and counting_semaphore_fifo_unit
`timescale 1ns / 1ps

module tb_counting_semaphore_fifo_unit;

  localparam int TID_W       = 6;
  localparam int DEPTH       = 16;
  localparam int COUNT_MAX   = 131071;
  localparam int IDLE_PCT    = 21;
  localparam int SETTLE      = 6;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BEATS = 31;

  // one result beat as the block reports it
  typedef struct packed {
    csf_pkg::kind_t   kind;
    logic [TID_W-1:0] tid;
    logic             last;
  } sem_result_t;

  // one row of the directed plan; want is used only when typed is set
  typedef struct {
    csf_pkg::func_t   op;
    logic [TID_W-1:0] tid;
    bit               typed;
    sem_result_t      want;
  } plan_row_t;

  localparam sem_result_t NONE = '{csf_pkg::KIND_PROCEED, 6'd0, 1'b0};

  // directed plan: extremes, every operation, ignored code, full ring, drain of a full ring
  plan_row_t plan [0:24] = '{
    '{csf_pkg::FUNC_SIGNAL, 6'd0,  1'b1, '{csf_pkg::KIND_NO_WAITER, 6'd0, 1'b1}},
    '{csf_pkg::FUNC_CLOSE,  6'd0,  1'b1, '{csf_pkg::KIND_NO_WAITER, 6'd0, 1'b1}},
    '{csf_pkg::FUNC_WAIT,   6'd63, 1'b1, '{csf_pkg::KIND_BLOCKED, 6'd63, 1'b1}},
    '{csf_pkg::FUNC_WAIT,   6'd0,  1'b1, '{csf_pkg::KIND_BLOCKED, 6'd0, 1'b1}},
    '{csf_pkg::FUNC_SIGNAL, 6'd0,  1'b1, '{csf_pkg::KIND_WOKEN_SIGNAL, 6'd63, 1'b1}},
    '{csf_pkg::FUNC_RSVD,   6'd21, 1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd42, 1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd1,  1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd2,  1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd4,  1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd8,  1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd16, 1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd32, 1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd62, 1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd61, 1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd59, 1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd55, 1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd47, 1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd31, 1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd21, 1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd10, 1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd63, 1'b1, '{csf_pkg::KIND_FULL, 6'd63, 1'b1}},
    '{csf_pkg::FUNC_SIGNAL, 6'd5,  1'b0, NONE},
    '{csf_pkg::FUNC_WAIT,   6'd37, 1'b0, NONE},
    '{csf_pkg::FUNC_CLOSE,  6'd9,  1'b0, NONE}
  };

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [csf_pkg::FUNC_W-1:0]   func;
  logic [TID_W-1:0]             thread_id;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [csf_pkg::KIND_W-1:0]   kind;
  logic [TID_W-1:0]             result_thread;
  logic                         last;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [csf_pkg::INIT_W-1:0]   cfg_data;

  // semaphore mirror
  int                           sem_count;
  logic [csf_pkg::INIT_W-1:0]   init_count;
  logic [TID_W-1:0]             waiters[$];
  sem_result_t                  fresh[$];
  sem_result_t                  due_results[$];

  bit                           steady;
  int                           mismatches;
  int                           stall_cycles;
  sem_result_t                  head;

  counting_semaphore_fifo_unit #(
    .WAIT_DEPTH    (DEPTH),
    .THREAD_ID_BITS(TID_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .thread_id    (thread_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .result_thread(result_thread),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // semaphore predictor: updates the mirror and leaves the results of one beat in fresh
  function automatic void sem_apply(input csf_pkg::func_t op, input logic [TID_W-1:0] tid);
    logic [TID_W-1:0] w;
    fresh.delete();
    case (op)
      csf_pkg::FUNC_WAIT: begin
        if (sem_count >= 1) begin
          sem_count--;
          fresh.push_back('{csf_pkg::KIND_PROCEED, tid, 1'b1});
        end else if (waiters.size() >= DEPTH) begin
          fresh.push_back('{csf_pkg::KIND_FULL, tid, 1'b1});
        end else begin
          sem_count--;
          waiters.push_back(tid);
          fresh.push_back('{csf_pkg::KIND_BLOCKED, tid, 1'b1});
        end
      end
      csf_pkg::FUNC_SIGNAL: begin
        if (sem_count < COUNT_MAX) sem_count++;
        if (waiters.size() > 0) begin
          w = waiters.pop_front();
          fresh.push_back('{csf_pkg::KIND_WOKEN_SIGNAL, w, 1'b1});
        end else begin
          fresh.push_back('{csf_pkg::KIND_NO_WAITER, 6'd0, 1'b1});
        end
      end
      csf_pkg::FUNC_CLOSE: begin
        if (waiters.size() == 0) begin
          fresh.push_back('{csf_pkg::KIND_NO_WAITER, 6'd0, 1'b1});
        end else begin
          while (waiters.size() > 0) begin
            w = waiters.pop_front();
            fresh.push_back('{csf_pkg::KIND_WOKEN_CLOSE, w, waiters.size() == 0});
          end
        end
        sem_count = int'(init_count);
      end
      default: ;
    endcase
  endfunction

  // request beat, entered and left at a falling edge; valid is only lowered by an idle gap
  task automatic send_beat(input csf_pkg::func_t op, input logic [TID_W-1:0] tid,
                           input bit typed, input sem_result_t want);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    func      <= op;
    thread_id <= tid;
    do @(posedge clk); while (!in_ready);
    sem_apply(op, tid);
    if (typed) due_results.push_back(want);
    else foreach (fresh[i]) due_results.push_back(fresh[i]);
    @(negedge clk);
  endtask

  // lower valid and wait for every expected beat, then let the block settle
  task automatic drain_block();
    in_valid <= 1'b0;
    @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // initial count write, only while the block is idle
  task automatic write_initial(input logic [csf_pkg::INIT_W-1:0] value);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    init_count = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result receiver stalls
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: kind %0d thread %0d last %0d",
                 $time, kind, result_thread, last);
      end else begin
        head = due_results.pop_front();
        if (kind !== head.kind) begin
          mismatches++;
          $display("%0t: kind expected %0d actual %0d", $time, head.kind, kind);
        end
        if (result_thread !== head.tid) begin
          mismatches++;
          $display("%0t: result_thread expected %0d actual %0d", $time, head.tid,
                   result_thread);
        end
        if (last !== head.last) begin
          mismatches++;
          $display("%0t: last expected %0d actual %0d", $time, head.last, last);
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [csf_pkg::INIT_W-1:0] phase_init [0:7];
    int                         placed;
    int                         wait_pct;
    int                         burst;
    int                         pick;
    csf_pkg::func_t             op;

    phase_init = '{16'd1, 16'd65535, 16'd0, 16'd3, 16'd0, 16'd2, 16'd0, 16'd5};
    phase_init[4] = 16'($urandom_range(65535));

    rst          = 1'b1;
    in_valid     = 1'b0;
    func         = csf_pkg::FUNC_WAIT;
    thread_id    = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    steady       = 1'b0;
    mismatches   = 0;
    stall_cycles = 0;
    sem_count    = 0;
    init_count   = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed plan
    foreach (plan[i]) send_beat(plan[i].op, plan[i].tid, plan[i].typed, plan[i].want);

    // random phases, each opened by a close so the new initial count takes effect
    for (int p = 0; p < 8; p++) begin
      write_initial(phase_init[p]);
      steady   = (p == 2);
      wait_pct = $urandom_range(40, 65);
      send_beat(csf_pkg::FUNC_CLOSE, TID_W'($urandom_range(63)), 1'b0, NONE);
      placed = 1;
      while (placed < PHASE_BEATS) begin
        if ($urandom_range(99) < 6) begin
          // burst of waits to fill the ring
          burst = $urandom_range(4, 18);
          repeat (burst)
            send_beat(csf_pkg::FUNC_WAIT, TID_W'($urandom_range(63)), 1'b0, NONE);
          placed += burst;
        end else begin
          pick = $urandom_range(99);
          if (pick < wait_pct)  op = csf_pkg::FUNC_WAIT;
          else if (pick < 94)   op = csf_pkg::FUNC_SIGNAL;
          else if (pick < 98)   op = csf_pkg::FUNC_CLOSE;
          else                  op = csf_pkg::FUNC_RSVD;
          send_beat(op, TID_W'($urandom_range(63)), 1'b0, NONE);
          if (op != csf_pkg::FUNC_RSVD) placed++;
        end
      end
      steady = 1'b0;
    end

    drain_block();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/csf_pkg.sv
rtl/csf_ctrl.sv
rtl/csf_datapath.sv
rtl/counting_semaphore_fifo_unit.sv
verif/tb_counting_semaphore_fifo_unit.sv
